### rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the palette effect engine: opcodes, effect
// codes, sweep kinds, controller states and controller/datapath structs.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int NUM_SLOTS_DEF = 4;
   localparam int NCOL          = 15;
   localparam int COL_STRIDE    = 16;
   localparam int COLOR_W       = 15;
   localparam int IDX_W         = 4;
   localparam int FRAME_W       = 8;
   localparam int PERIOD_W      = 6;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [COLOR_W-1:0] HALF_MASK = 15'h3DEF;
   localparam logic [COLOR_W-1:0] WHITE     = 15'h7FFF;

   localparam logic [FRAME_W-1:0] FLASH_DEF_RESET = 8'd6;
   localparam logic [FRAME_W-1:0] FADE_DEF_RESET  = 8'd30;

   localparam int FADE_DIV   = 5;
   localparam int FADE_RECIP = 205;
   localparam int FADE_SHIFT = 10;

   localparam logic REG_FLASH_DEFAULT = 1'b0;
   localparam logic REG_FADE_DEFAULT  = 1'b1;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_EFFECT = 3'd1,
      OP_TICK   = 3'd2,
      OP_PUSH   = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      EFX_RESTORE = 2'd0,
      EFX_FLASH   = 2'd1,
      EFX_FADE    = 2'd2,
      EFX_DARKEN  = 2'd3
   } effect_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_FLASH = 2'd1,
      MODE_FADE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_COPY  = 2'd0,
      KIND_HALVE = 2'd1,
      KIND_ZERO  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_RUN   = 2'd2,
      ST_DRAIN = 2'd3
   } state_type;

   typedef struct packed {
      logic accept;
      logic select;
      logic run;
   } pee_cmd_type;

   typedef struct packed {
      logic pend_any;
      logic idx_last;
   } pee_stat_type;

endpackage

### rtl/pee_csr.sv
// ----------------------------------------------------------------------------
// pee_csr
// APB register file holding the default flash and fade lengths.
// ----------------------------------------------------------------------------
module pee_csr import pee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [FRAME_W-1:0]    flash_frames,
   output logic [FRAME_W-1:0]    fade_frames
);

   logic [FRAME_W-1:0] flash_ff, flash_in;
   logic [FRAME_W-1:0] fade_ff, fade_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      flash_in = flash_ff;
      fade_in  = fade_ff;
      if (wr_en) begin
         if (paddr[2] == REG_FLASH_DEFAULT) begin
            flash_in = pwdata[FRAME_W-1:0];
         end else begin
            fade_in = pwdata[FRAME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_ff <= FLASH_DEF_RESET;
         fade_ff  <= FADE_DEF_RESET;
      end else begin
         flash_ff <= flash_in;
         fade_ff  <= fade_in;
      end
   end

   always_comb begin
      if (paddr[2] == REG_FLASH_DEFAULT) begin
         prdata = CSR_DATA_W'(flash_ff);
      end else begin
         prdata = CSR_DATA_W'(fade_ff);
      end
   end

   assign flash_frames = flash_ff;
   assign fade_frames  = fade_ff;

endmodule

### rtl/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl
// Sequencer: accepts a transaction, then walks pending slots one at a time,
// sweeping fifteen palette entries per slot.
// ----------------------------------------------------------------------------
module pee_ctrl import pee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  pee_stat_type stat,
   output pee_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = stat.pend_any ? ST_RUN : ST_IDLE;
         end
         ST_RUN: begin
            if (stat.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      cmd.accept = (state_ff == ST_IDLE) && start;
      cmd.select = (state_ff == ST_SCAN) && stat.pend_any;
      cmd.run    = (state_ff == ST_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/pee_dp.sv
// ----------------------------------------------------------------------------
// pee_dp
// Datapath: original and working palette memories, per-slot effect timers,
// dirty and pending masks, and the read/modify/write sweep pipeline.
// ----------------------------------------------------------------------------
module pee_dp import pee_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pee_cmd_type        cmd,
   output pee_stat_type       stat,
   input  logic [2:0]         req_opcode,
   input  logic [1:0]         req_slot,
   input  logic [3:0]         req_color_index,
   input  logic [14:0]        req_color_value,
   input  logic [1:0]         req_effect,
   input  logic [7:0]         req_duration,
   input  logic [FRAME_W-1:0] flash_frames,
   input  logic [FRAME_W-1:0] fade_frames,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_out_slot,
   output logic [3:0]         rsp_out_index,
   output logic [14:0]        rsp_out_color,
   output logic               rsp_last
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int DEPTH  = NUM_SLOTS * COL_STRIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [COLOR_W-1:0] orig_mem [DEPTH];
   logic [COLOR_W-1:0] work_mem [DEPTH];

   logic [NUM_SLOTS-1:0] occ_ff, occ_in;
   logic [NUM_SLOTS-1:0] dirty_ff, dirty_in;
   logic [NUM_SLOTS-1:0] pend_ff, pend_in;
   mode_type             mode_ff [NUM_SLOTS];
   mode_type             mode_in [NUM_SLOTS];
   kind_type             pkind_ff [NUM_SLOTS];
   kind_type             pkind_in [NUM_SLOTS];
   logic [FRAME_W-1:0]   frames_ff [NUM_SLOTS];
   logic [FRAME_W-1:0]   frames_in [NUM_SLOTS];
   logic [PERIOD_W-1:0]  period_ff [NUM_SLOTS];
   logic [PERIOD_W-1:0]  period_in [NUM_SLOTS];
   logic [PERIOD_W-1:0]  pcount_ff [NUM_SLOTS];
   logic [PERIOD_W-1:0]  pcount_in [NUM_SLOTS];

   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   kind_type           cur_kind_ff, cur_kind_in;
   logic               cur_flash_ff, cur_flash_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               stg_valid_ff;
   logic [IDX_W-1:0]   stg_idx_ff;
   logic [ADDR_W-1:0]  stg_addr_ff;
   logic [COLOR_W-1:0] orig_rd_ff;
   logic [COLOR_W-1:0] work_rd_ff;

   logic               slot_ok;
   logic [SLOT_W-1:0]  slot_i;
   logic [PERIOD_W-1:0] fade_q;
   logic [PERIOD_W-1:0] fade_per;
   logic [FRAME_W-1:0] dur_flash;
   logic [FRAME_W-1:0] dur_fade;
   logic [SLOT_W-1:0]  push_slot;
   logic [SLOT_W-1:0]  sel_slot;
   logic               ld_we;
   logic [ADDR_W-1:0]  ld_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               stg_we;
   logic [COLOR_W-1:0] wr_data;
   logic [FRAME_W-1:0] frames_dec;
   logic [PERIOD_W-1:0] pcount_dec;

   assign slot_ok   = (32'(req_slot) < NUM_SLOTS);
   assign slot_i    = SLOT_W'(req_slot);
   assign fade_q    = PERIOD_W'((16'(req_duration) * 16'(FADE_RECIP)) >> FADE_SHIFT);
   assign fade_per  = (req_duration >= 8'(FADE_DIV)) ? fade_q : PERIOD_W'(1);
   assign dur_flash = (req_duration != '0) ? req_duration : flash_frames;
   assign dur_fade  = (req_duration != '0) ? req_duration : fade_frames;

   assign ld_we   = cmd.accept && (req_opcode == OP_LOAD) && slot_ok
                    && (req_color_index != IDX_W'(NCOL));
   assign ld_addr = ADDR_W'({slot_i, req_color_index});
   assign rd_addr = ADDR_W'({cur_slot_ff, idx_ff});

   always_comb begin
      push_slot = '0;
      sel_slot  = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (dirty_ff[s]) begin
            push_slot = SLOT_W'(s);
         end
         if (pend_ff[s]) begin
            sel_slot = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      occ_in     = occ_ff;
      dirty_in   = dirty_ff;
      pend_in    = pend_ff;
      mode_in    = mode_ff;
      pkind_in   = pkind_ff;
      frames_in  = frames_ff;
      period_in  = period_ff;
      pcount_in  = pcount_ff;
      frames_dec = '0;
      pcount_dec = '0;
      if (cmd.accept) begin
         unique case (req_opcode)
            OP_LOAD: begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (ld_we && (SLOT_W'(s) == slot_i)) begin
                     occ_in[s]   = 1'b1;
                     mode_in[s]  = MODE_NONE;
                     dirty_in[s] = 1'b1;
                  end
               end
            end
            OP_EFFECT: begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (slot_ok && (SLOT_W'(s) == slot_i) && occ_ff[s]) begin
                     unique case (req_effect)
                        EFX_RESTORE: begin
                           mode_in[s]  = MODE_NONE;
                           dirty_in[s] = 1'b1;
                           pend_in[s]  = 1'b1;
                           pkind_in[s] = KIND_COPY;
                        end
                        EFX_FLASH: begin
                           mode_in[s]   = MODE_FLASH;
                           frames_in[s] = dur_flash;
                           dirty_in[s]  = 1'b1;
                        end
                        EFX_FADE: begin
                           mode_in[s]   = MODE_FADE;
                           frames_in[s] = dur_fade;
                           period_in[s] = fade_per;
                           pcount_in[s] = fade_per;
                        end
                        EFX_DARKEN: begin
                           dirty_in[s] = 1'b1;
                           pend_in[s]  = 1'b1;
                           pkind_in[s] = KIND_HALVE;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            OP_TICK: begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  frames_dec = frames_ff[s] - 1'b1;
                  pcount_dec = pcount_ff[s] - 1'b1;
                  if (mode_ff[s] == MODE_FLASH) begin
                     frames_in[s] = frames_dec;
                     if (frames_dec == '0) begin
                        mode_in[s]  = MODE_NONE;
                        dirty_in[s] = 1'b1;
                     end
                  end else if (mode_ff[s] == MODE_FADE) begin
                     frames_in[s] = frames_dec;
                     if (frames_dec == '0) begin
                        mode_in[s]  = MODE_NONE;
                        dirty_in[s] = 1'b1;
                        pend_in[s]  = 1'b1;
                        pkind_in[s] = KIND_ZERO;
                     end else if (pcount_dec == '0) begin
                        pcount_in[s] = period_ff[s];
                        dirty_in[s]  = 1'b1;
                        pend_in[s]   = 1'b1;
                        pkind_in[s]  = KIND_HALVE;
                     end else begin
                        pcount_in[s] = pcount_dec;
                     end
                  end
               end
            end
            OP_PUSH: begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if ((|dirty_ff) && (SLOT_W'(s) == push_slot)) begin
                     dirty_in[s] = 1'b0;
                     pend_in[s]  = 1'b1;
                     pkind_in[s] = KIND_READ;
                  end
               end
            end
            OP_CLEAR: begin
               occ_in   = '0;
               dirty_in = '0;
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  mode_in[s]   = MODE_NONE;
                  frames_in[s] = '0;
                  period_in[s] = '0;
                  pcount_in[s] = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.select) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (SLOT_W'(s) == sel_slot) begin
               pend_in[s] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      cur_slot_in  = cur_slot_ff;
      cur_kind_in  = cur_kind_ff;
      cur_flash_in = cur_flash_ff;
      idx_in       = idx_ff;
      if (cmd.select) begin
         cur_slot_in  = sel_slot;
         cur_kind_in  = pkind_ff[sel_slot];
         cur_flash_in = (mode_ff[sel_slot] == MODE_FLASH);
         idx_in       = '0;
      end else if (cmd.run) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      unique case (cur_kind_ff)
         KIND_COPY:  wr_data = orig_rd_ff;
         KIND_HALVE: wr_data = (work_rd_ff >> 1) & HALF_MASK;
         KIND_ZERO:  wr_data = '0;
         KIND_READ:  wr_data = work_rd_ff;
         default:    wr_data = '0;
      endcase
   end

   assign stg_we = stg_valid_ff && (cur_kind_ff != KIND_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         dirty_ff     <= '0;
         pend_ff      <= '0;
         stg_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            mode_ff[s]   <= MODE_NONE;
            frames_ff[s] <= '0;
            period_ff[s] <= '0;
            pcount_ff[s] <= '0;
         end
      end else begin
         occ_ff       <= occ_in;
         dirty_ff     <= dirty_in;
         pend_ff      <= pend_in;
         stg_valid_ff <= cmd.run;
         mode_ff      <= mode_in;
         frames_ff    <= frames_in;
         period_ff    <= period_in;
         pcount_ff    <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      pkind_ff     <= pkind_in;
      cur_slot_ff  <= cur_slot_in;
      cur_kind_ff  <= cur_kind_in;
      cur_flash_ff <= cur_flash_in;
      idx_ff       <= idx_in;
      stg_idx_ff   <= idx_ff;
      stg_addr_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         orig_mem[ld_addr] <= req_color_value;
      end
      orig_rd_ff <= orig_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         work_mem[ld_addr] <= req_color_value;
      end else if (stg_we) begin
         work_mem[stg_addr_ff] <= wr_data;
      end
      work_rd_ff <= work_mem[rd_addr];
   end

   assign stat.pend_any = |pend_ff;
   assign stat.idx_last = (idx_ff == IDX_W'(NCOL - 1));

   assign rsp_strobe    = stg_valid_ff && (cur_kind_ff == KIND_READ);
   assign rsp_out_slot  = 2'(cur_slot_ff);
   assign rsp_out_index = stg_idx_ff;
   assign rsp_out_color = cur_flash_ff ? WHITE : work_rd_ff;
   assign rsp_last      = (stg_idx_ff == IDX_W'(NCOL - 1));

endmodule

### rtl/palette_effect_engine.sv
// ----------------------------------------------------------------------------
// palette_effect_engine
// Per-slot 15-colour BGR555 palettes with restore, flash, fade and darken.
// ----------------------------------------------------------------------------
// Load, effect start, clear, empty push: no sweep; busy only in the scan state.
// Restore or darken of a loaded slot, push of a dirty slot: one 15-entry sweep,
// busy through scan, run, drain and a final scan; a push strobes the colours in order.
// Tick: busy for a scan plus one sweep per slot that halves or blacks out.
// Results are strobed once and cannot be stalled.
// Reset clears slots, timers and dirty bits; palette RAM is not cleared.
module palette_effect_engine import pee_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_opcode,
   input  logic [1:0]            req_slot,
   input  logic [3:0]            req_color_index,
   input  logic [14:0]           req_color_value,
   input  logic [1:0]            req_effect,
   input  logic [7:0]            req_duration,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_out_slot,
   output logic [3:0]            rsp_out_index,
   output logic [14:0]           rsp_out_color,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pee_cmd_type        cmd;
   pee_stat_type       stat;
   logic [FRAME_W-1:0] flash_frames;
   logic [FRAME_W-1:0] fade_frames;

   pee_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .flash_frames (flash_frames),
      .fade_frames  (fade_frames)
   );

   pee_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pee_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_color_index (req_color_index),
      .req_color_value (req_color_value),
      .req_effect      (req_effect),
      .req_duration    (req_duration),
      .flash_frames    (flash_frames),
      .fade_frames     (fade_frames),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_slot    (rsp_out_slot),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_color   (rsp_out_color),
      .rsp_last        (rsp_last)
   );

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobed while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=>
         (rsp_strobe && (rsp_out_index == $past(rsp_out_index) + 4'd1)
          && (rsp_out_slot == $past(rsp_out_slot))))
      else $error("push burst broke sequence");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result strobed after last colour");

endmodule
